// ===== src/lrc_pkg.sv =====
package lrc_pkg;

    localparam int DEF_ENTRIES = 8;
    localparam int MAX_ENTRIES = 64;
    localparam int POS_W       = $clog2(MAX_ENTRIES);
    localparam int KEY_W       = 16;
    localparam int PRICE_W     = 32;
    localparam int CUT_W       = 16;
    localparam int USES_W      = 16;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [PRICE_W-1:0] t_price;
    typedef logic [CUT_W-1:0]  t_cut;
    typedef logic [USES_W-1:0] t_uses;

    localparam t_uses USES_MAX  = '1;
    localparam t_uses USES_INIT = t_uses'(1);

    typedef enum logic {
        POL_LRU = 1'b0,
        POL_LFU = 1'b1
    } t_policy;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_BUMP
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_key   key;
        t_price price;
        t_cut   cut;
        t_uses  uses;
    } t_entry;

    // Search token that walks down the row of cells
    typedef struct packed {
        t_key   key;
        logic   m_found;
        t_pos   m_pos;
        t_price m_price;
        t_cut   m_cut;
        t_uses  m_uses;
        logic   v_found;
        t_pos   v_pos;
        t_key   v_key;
        t_uses  v_uses;
        logic   f_found;
        t_pos   f_pos;
    } t_scan;

    typedef struct packed {
        t_cell_op op;
        t_pos     lim;
    } t_cell_ctl;

    typedef struct packed {
        logic   hit;
        t_price found_price;
        t_cut   found_cut;
        t_uses  hit_count;
        logic   evicted;
        t_key   evicted_key;
    } t_result;

    function automatic t_uses sat_inc(input t_uses u);
        return (u == USES_MAX) ? u : t_uses'(u + 1'b1);
    endfunction

endpackage

// ===== src/lrc_if.sv =====
interface lrc_in_if import lrc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   kind;
    t_key   key;
    t_price price;
    t_cut   cut;

    modport source (output valid, output kind, output key, output price, output cut,
                    input ready);
    modport sink   (input valid, input kind, input key, input price, input cut,
                    output ready);
endinterface

interface lrc_out_if import lrc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    t_price found_price;
    t_cut   found_cut;
    t_uses  hit_count;
    logic   evicted;
    t_key   evicted_key;

    modport source (output valid, output hit, output found_price, output found_cut,
                    output hit_count, output evicted, output evicted_key, input ready);
    modport sink   (input valid, input hit, input found_price, input found_cut,
                    input hit_count, input evicted, input evicted_key, output ready);
endinterface

// ===== src/lrc_cell.sv =====
module lrc_cell import lrc_pkg::*; #(
    parameter int POS = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_policy   i_policy,
    input  logic      i_tok_valid,
    input  t_scan     i_tok,
    output logic      o_tok_valid,
    output t_scan     o_tok,
    input  logic      i_left_valid,
    input  t_entry    i_left,
    output logic      o_valid,
    output t_entry    o_entry,
    input  t_cell_ctl i_ctl
);

    localparam t_pos MY_POS = t_pos'(POS);

    logic   r_valid;
    t_entry r_entry;
    logic   r_tok_valid;
    t_scan  r_tok;
    t_scan  n_tok;
    logic   sel_le;
    logic   sel_eq;

    always_comb begin
        n_tok = i_tok;
        // first match in order wins
        if (r_valid && (r_entry.key == i_tok.key) && !i_tok.m_found) begin
            n_tok.m_found = 1'b1;
            n_tok.m_pos   = MY_POS;
            n_tok.m_price = r_entry.price;
            n_tok.m_cut   = r_entry.cut;
            n_tok.m_uses  = r_entry.uses;
        end
        // LRU keeps the last valid cell, LFU the first with the least count
        if (r_valid && (!i_tok.v_found || (i_policy == POL_LRU) ||
                        (r_entry.uses < i_tok.v_uses))) begin
            n_tok.v_found = 1'b1;
            n_tok.v_pos   = MY_POS;
            n_tok.v_key   = r_entry.key;
            n_tok.v_uses  = r_entry.uses;
        end
        if (!r_valid && !i_tok.f_found) begin
            n_tok.f_found = 1'b1;
            n_tok.f_pos   = MY_POS;
        end
    end

    assign sel_le = (MY_POS <= i_ctl.lim);
    assign sel_eq = (MY_POS == i_ctl.lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
        if (i_tok_valid) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                CELL_SHIFT: begin
                    if (sel_le) begin
                        r_valid <= i_left_valid;
                        r_entry <= i_left;
                    end
                end
                CELL_BUMP: begin
                    if (sel_eq) begin
                        r_entry.uses <= sat_inc(r_entry.uses);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;
    assign o_valid     = r_valid;
    assign o_entry     = r_entry;

endmodule

// ===== src/lru_lfu_result_cache.sv =====
// A request is taken only when idle, once the update for the previous one is applied;
// the search token walks the row of entry cells one cell per cycle, then the update
// is applied once the output register is free, and the result is registered.
// A waiting result does not block the next request from being taken.
// Reset (synchronous, active low): cache empty, policy LRU, output empty.
module lru_lfu_result_cache import lrc_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    lrc_in_if.sink           i_req,
    lrc_out_if.source        o_rsp
);

    t_state    r_state;
    t_state    n_state;
    t_policy   r_policy;
    t_kind     r_kind;
    t_price    r_price;
    t_cut      r_cut;
    logic      r_tok_v;
    t_scan     r_tok;
    logic      r_out_valid;
    t_result   r_res;

    logic      in_ready;
    logic      out_free;
    logic      apply;
    t_cell_ctl ctl;
    t_cell_ctl ctl_d;
    t_entry    new_entry;
    t_result   res;
    t_scan     fin;
    t_scan     init_tok;

    t_scan             tok [ENTRIES+1];
    logic [ENTRIES:0]  tok_v;
    t_entry            ent [ENTRIES+1];
    logic [ENTRIES:0]  ent_v;
    logic [ENTRIES-1:0] cell_vld;

    assign tok[0]   = r_tok;
    assign tok_v[0] = r_tok_v;
    assign ent[0]   = new_entry;
    assign ent_v[0] = 1'b1;
    assign fin      = tok[ENTRIES];
    assign cell_vld = ent_v[ENTRIES:1];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrc_cell #(
            .POS (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_policy     (r_policy),
            .i_tok_valid  (tok_v[g]),
            .i_tok        (tok[g]),
            .o_tok_valid  (tok_v[g+1]),
            .o_tok        (tok[g+1]),
            .i_left_valid (ent_v[g]),
            .i_left       (ent[g]),
            .o_valid      (ent_v[g+1]),
            .o_entry      (ent[g+1]),
            .i_ctl        (ctl)
        );
    end

    always_comb begin
        init_tok     = '0;
        init_tok.key = i_req.key;
    end

    // Work out the update from the finished search token
    always_comb begin
        res       = '0;
        ctl_d     = '0;
        ctl_d.op  = CELL_HOLD;
        new_entry = '{key: fin.key, price: r_price, cut: r_cut, uses: USES_INIT};
        case (r_kind)
            KIND_LOOKUP: begin
                if (fin.m_found) begin
                    res.hit         = 1'b1;
                    res.found_price = fin.m_price;
                    res.found_cut   = fin.m_cut;
                    ctl_d.lim       = fin.m_pos;
                    if (r_policy == POL_LRU) begin
                        ctl_d.op      = CELL_SHIFT;
                        res.hit_count = fin.m_uses;
                        new_entry     = '{key: fin.key, price: fin.m_price,
                                          cut: fin.m_cut, uses: fin.m_uses};
                    end else begin
                        ctl_d.op      = CELL_BUMP;
                        res.hit_count = sat_inc(fin.m_uses);
                    end
                end
            end
            default: begin
                ctl_d.op = CELL_SHIFT;
                if (fin.f_found) begin
                    ctl_d.lim = fin.f_pos;
                end else begin
                    ctl_d.lim       = fin.v_pos;
                    res.evicted     = 1'b1;
                    res.evicted_key = fin.v_key;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_SCAN;
            ST_SCAN: if (tok_v[ENTRIES]) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        apply    = 1'b0;
        ctl      = '0;
        ctl.op   = CELL_HOLD;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_DONE: begin
                apply = out_free;
                if (out_free) begin
                    ctl = ctl_d;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_policy    <= POL_LRU;
            r_tok_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok_v <= i_req.valid && in_ready;
            if (i_cfg_we) begin
                r_policy <= t_policy'(i_cfg_wdata);
            end
            if (apply) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_tok   <= init_tok;
            r_kind  <= t_kind'(i_req.kind);
            r_price <= i_req.price;
            r_cut   <= i_req.cut;
        end
        if (apply) begin
            r_res <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_res.hit;
    assign o_rsp.found_price = r_res.found_price;
    assign o_rsp.found_cut   = r_res.found_cut;
    assign o_rsp.hit_count   = r_res.hit_count;
    assign o_rsp.evicted     = r_res.evicted;
    assign o_rsp.evicted_key = r_res.evicted_key;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_v))
        else $error("more than one search token in the cell row");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_v[ENTRIES] |-> (r_state == ST_SCAN))
        else $error("search token reached the tail outside of a scan");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ENTRIES'(cell_vld + 1'b1) & cell_vld) == '0))
        else $error("valid entries do not form a prefix of the row");

    a_apply_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("applied update did not produce a result");

    a_hit_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.hit && r_res.evicted))
        else $error("result reports both a hit and an eviction");

endmodule
